// ----- hw/rtl/mse_pkg.sv -----
// Package for the Morse symbol encoder: symbol codes, code tables and the
// character lookup function. No dependencies.
`default_nettype none

package mse_pkg;

  localparam int MaxResults = 8;
  localparam int IdxW       = $clog2(MaxResults);
  localparam int CodeBits   = 7;

  typedef enum logic [1:0] {
    SYM_DOT     = 2'd0,
    SYM_DASH    = 2'd1,
    SYM_GAP     = 2'd2,
    SYM_UNKNOWN = 2'd3
  } sym_t;

  // One dot/dash code: its length and its pattern, first symbol in the
  // most significant used bit, 1 for a dash.
  typedef struct packed {
    logic [2:0]          len;
    logic [CodeBits-1:0] bits;
  } code_t;

  // The whole symbol sequence of one character.
  typedef struct packed {
    logic [IdxW-1:0]                last_idx;
    logic [MaxResults-1:0][1:0]     sym;
  } seq_t;

  typedef struct packed {
    logic active;
    logic on_last;
  } ser_status_t;

  localparam code_t LatinCodes [26] = '{
    {3'd2, 7'b0000001}, {3'd4, 7'b0001000}, {3'd4, 7'b0001010}, {3'd3, 7'b0000100},
    {3'd1, 7'b0000000}, {3'd4, 7'b0000010}, {3'd3, 7'b0000110}, {3'd4, 7'b0000000},
    {3'd2, 7'b0000000}, {3'd4, 7'b0000111}, {3'd3, 7'b0000101}, {3'd4, 7'b0000100},
    {3'd2, 7'b0000011}, {3'd2, 7'b0000010}, {3'd3, 7'b0000111}, {3'd4, 7'b0000110},
    {3'd4, 7'b0001101}, {3'd3, 7'b0000010}, {3'd3, 7'b0000000}, {3'd1, 7'b0000001},
    {3'd3, 7'b0000001}, {3'd4, 7'b0000001}, {3'd3, 7'b0000011}, {3'd4, 7'b0001001},
    {3'd4, 7'b0001011}, {3'd4, 7'b0001100}
  };

  localparam code_t CyrCodes [32] = '{
    {3'd2, 7'b0000001}, {3'd4, 7'b0001000}, {3'd3, 7'b0000011}, {3'd3, 7'b0000110},
    {3'd3, 7'b0000100}, {3'd1, 7'b0000000}, {3'd4, 7'b0000001}, {3'd4, 7'b0001100},
    {3'd2, 7'b0000000}, {3'd4, 7'b0000111}, {3'd3, 7'b0000101}, {3'd4, 7'b0000100},
    {3'd2, 7'b0000011}, {3'd2, 7'b0000010}, {3'd3, 7'b0000111}, {3'd4, 7'b0000110},
    {3'd3, 7'b0000010}, {3'd3, 7'b0000000}, {3'd1, 7'b0000001}, {3'd3, 7'b0000001},
    {3'd4, 7'b0000010}, {3'd4, 7'b0000000}, {3'd4, 7'b0001010}, {3'd4, 7'b0001110},
    {3'd4, 7'b0001111}, {3'd4, 7'b0001101}, {3'd6, 7'b0011010}, {3'd4, 7'b0001011},
    {3'd4, 7'b0001001}, {3'd7, 7'b0001000}, {3'd4, 7'b0000011}, {3'd4, 7'b0000101}
  };

  localparam code_t DigitCodes [10] = '{
    {3'd5, 7'b0011111}, {3'd5, 7'b0001111}, {3'd5, 7'b0000111}, {3'd5, 7'b0000011},
    {3'd5, 7'b0000001}, {3'd5, 7'b0000000}, {3'd5, 7'b0010000}, {3'd5, 7'b0011000},
    {3'd5, 7'b0011100}, {3'd5, 7'b0011110}
  };

  localparam logic [7:0] CharSpace = 8'h20;

  // Full symbol sequence for one character byte.
  function automatic seq_t char_to_seq(input logic [7:0] c);
    code_t               code;
    logic                known;
    logic [7:0]          ofs_up;
    logic [7:0]          ofs_lo;
    logic [CodeBits-1:0] aligned;
    seq_t                seq;
    code    = '0;
    known   = 1'b1;
    ofs_up  = c - 8'h41;
    ofs_lo  = c - 8'h61;
    seq     = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      code = LatinCodes[ofs_up[4:0]];
    end else if (c inside {[8'h61:8'h7A]}) begin
      code = LatinCodes[ofs_lo[4:0]];
    end else if (c inside {[8'hC0:8'hFF]}) begin
      code = CyrCodes[c[4:0]];
    end else if (c inside {[8'h30:8'h39]}) begin
      code = DigitCodes[c[3:0]];
    end else begin
      case (c)
        8'hA8, 8'hB8: code = {3'd1, 7'b0000000};
        8'h2C:        code = {3'd6, 7'b0110011};
        8'h2E:        code = {3'd6, 7'b0010101};
        8'h3B:        code = {3'd6, 7'b0101010};
        8'h3A:        code = {3'd6, 7'b0111000};
        8'h3F:        code = {3'd6, 7'b0001100};
        8'h2D:        code = {3'd6, 7'b0100001};
        8'h2F:        code = {3'd5, 7'b0010010};
        default:      known = 1'b0;
      endcase
    end
    if (c == CharSpace) begin
      seq.sym[0]   = SYM_GAP;
      seq.sym[1]   = SYM_GAP;
      seq.last_idx = IdxW'(1);
    end else if (!known) begin
      seq.sym[0]   = SYM_UNKNOWN;
      seq.sym[1]   = SYM_GAP;
      seq.last_idx = IdxW'(1);
    end else begin
      // Left-align the pattern so that symbol i sits at a fixed bit.
      aligned = code.bits << (3'd7 - code.len);
      for (int i = 0; i < MaxResults; i++) begin
        if (i < 32'(code.len)) begin
          seq.sym[i] = aligned[CodeBits-1-i] ? SYM_DASH : SYM_DOT;
        end else if (i == 32'(code.len)) begin
          seq.sym[i] = SYM_GAP;
        end
      end
      seq.last_idx = IdxW'(code.len);
    end
    return seq;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mse_serializer.sv -----
// Symbol serialiser of the Morse symbol encoder: holds one character's
// sequence and emits one symbol per cycle. Depends on mse_pkg.
`default_nettype none

module mse_serializer (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire mse_pkg::seq_t          seq,
  output mse_pkg::ser_status_t        status,
  output logic                        out_strobe,
  output logic [1:0]                  out_symbol,
  output logic                        out_last
);

  mse_pkg::seq_t                seq_r;
  logic [mse_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic                         active_r, active_nxt;
  logic                         on_last;

  assign on_last = active_r && (idx_r == seq_r.last_idx);

  always_comb begin
    idx_nxt    = idx_r;
    active_nxt = active_r;
    if (load) begin
      idx_nxt    = '0;
      active_nxt = 1'b1;
    end else if (on_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      active_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq_r <= seq;
    end
  end

  assign status.active  = active_r;
  assign status.on_last = on_last;
  assign out_strobe     = active_r;
  assign out_symbol     = seq_r.sym[idx_r];
  assign out_last       = on_last;

endmodule

`default_nettype wire

// ----- hw/rtl/morse_symbol_encoder.sv -----
// Top level of the Morse symbol encoder: request register, character lookup
// and serialiser. Depends on mse_pkg and mse_serializer.
`default_nettype none

// A request of one code page 1251 byte is taken when start is high and busy
// is low. It yields n+1 result symbols (n dots and dashes, then a gap marked
// last; two symbols for a space or an unmapped byte), so between 2 and 8
// results, one per cycle, with out_strobe high; the first appears after the
// input register and the serialiser's state registers. The serialiser's one
// symbol per cycle sets the sustained rate; successive characters follow
// without a break when the next request already waits. One request waits
// in the input register while the previous character is serialised. The
// receiver cannot stall, so every strobed symbol must be taken in its cycle.
module morse_symbol_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_char_code,
  output logic            out_strobe,
  output logic [1:0]      out_symbol,
  output logic            out_last
);

  logic                  hold_valid_r, hold_valid_nxt;
  logic [7:0]            hold_char_r;
  logic                  accept;
  logic                  ser_free;
  logic                  load;
  mse_pkg::seq_t         seq;
  mse_pkg::ser_status_t  ser_status;

  assign ser_free = !ser_status.active || ser_status.on_last;
  assign load     = hold_valid_r && ser_free;
  assign busy     = hold_valid_r && !ser_free;
  assign accept   = start && !busy;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_char_r <= in_char_code;
    end
  end

  assign seq = mse_pkg::char_to_seq(hold_char_r);

  mse_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .seq        (seq),
    .status     (ser_status),
    .out_strobe (out_strobe),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

  // The symbols of one character come without a hole.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("symbol stream broke inside a character");

  // Every character ends in a gap.
  a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> out_symbol == mse_pkg::SYM_GAP)
    else $error("last symbol is not a gap");

  // A waiting request is handed on as soon as the serialiser frees up.
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && !busy |=> out_strobe && !$past(out_last && !load))
    else $error("waiting request was not handed to the serialiser");

  // From idle, an accepted request strobes via hold_valid_r and active_r.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !hold_valid_r && !out_strobe |=> ##1 out_strobe)
    else $error("accepted request produced no symbol");

endmodule

`default_nettype wire
